>>> design/ckp_pkg.sv
`default_nettype none

package ckp_pkg;

    // Key codes
    localparam logic [2:0] BTN_NONE   = 3'd0;
    localparam logic [2:0] BTN_RIGHT  = 3'd1;
    localparam logic [2:0] BTN_UP     = 3'd2;
    localparam logic [2:0] BTN_DOWN   = 3'd3;
    localparam logic [2:0] BTN_LEFT   = 3'd4;
    localparam logic [2:0] BTN_SELECT = 3'd5;

    // Edited field codes
    localparam logic [1:0] FLD_HOUR   = 2'd0;
    localparam logic [1:0] FLD_MINUTE = 2'd1;
    localparam logic [1:0] FLD_SECOND = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TICKS_PER_SECOND = 1'b0;
    localparam logic CFG_KEY_TOLERANCE    = 1'b1;

    // Key window centers on the resistor ladder
    localparam logic [10:0] CENTER_UP     = 11'd145;
    localparam logic [10:0] CENTER_DOWN   = 11'd329;
    localparam logic [10:0] CENTER_LEFT   = 11'd505;
    localparam logic [10:0] CENTER_SELECT = 11'd740;

    localparam logic [4:0] HOUR_MAX = 5'd23;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [5:0] SEC_MAX  = 6'd59;

    localparam logic [7:0] TPS_RESET = 8'd125;
    localparam logic [5:0] TOL_RESET = 6'd10;

    typedef struct packed {
        logic [4:0] hour_value;
        logic [5:0] minute_value;
        logic [5:0] second_value;
        logic [1:0] selected_field;
        logic [2:0] key_code;
        logic       refresh;
    } t_result;

endpackage

`default_nettype wire

>>> design/ckp_key_decode.sv
`default_nettype none

module ckp_key_decode (
    input  wire logic [9:0] i_sample,
    input  wire logic [5:0] i_tol,
    output logic      [2:0] o_key
);

    logic [10:0] w_v;
    logic [10:0] w_tol;

    function automatic logic in_win(input logic [10:0] v, input logic [10:0] c,
                                    input logic [10:0] tol);
        in_win = ((v + tol) >= c) && (v <= (c + tol));
    endfunction

    assign w_v   = {1'b0, i_sample};
    assign w_tol = {5'd0, i_tol};

    // later keys in ladder order take priority where windows overlap
    always_comb begin
        o_key = ckp_pkg::BTN_NONE;
        if (w_v <= w_tol) o_key = ckp_pkg::BTN_RIGHT;
        if (in_win(w_v, ckp_pkg::CENTER_UP, w_tol)) o_key = ckp_pkg::BTN_UP;
        if (in_win(w_v, ckp_pkg::CENTER_DOWN, w_tol)) o_key = ckp_pkg::BTN_DOWN;
        if (in_win(w_v, ckp_pkg::CENTER_LEFT, w_tol)) o_key = ckp_pkg::BTN_LEFT;
        if (in_win(w_v, ckp_pkg::CENTER_SELECT, w_tol)) o_key = ckp_pkg::BTN_SELECT;
    end

endmodule

`default_nettype wire

>>> design/ckp_time_core.sv
`default_nettype none

module ckp_time_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [2:0]       i_key,
    input  wire logic [7:0]       i_tps,
    output ckp_pkg::t_result      o_res
);

    logic [7:0] r_tick, n_tick;
    logic [4:0] r_hour, n_hour;
    logic [5:0] r_min,  n_min;
    logic [5:0] r_sec,  n_sec;
    logic [1:0] r_fld,  n_fld;
    logic [2:0] r_last;
    ckp_pkg::t_result r_res;

    logic [8:0] w_next_cnt;
    logic       w_sec_tick;
    logic       w_key_new;
    logic [4:0] w_hour_c;
    logic [5:0] w_min_c;
    logic [5:0] w_sec_c;
    logic       w_up;

    assign w_next_cnt = {1'b0, r_tick} + 9'd1;
    assign w_sec_tick = w_next_cnt >= {1'b0, i_tps};
    assign w_key_new  = (i_key != ckp_pkg::BTN_NONE) && (i_key != r_last);
    assign w_up       = (i_key == ckp_pkg::BTN_UP);

    always_comb begin
        // seconds carry chain
        w_sec_c  = r_sec;
        w_min_c  = r_min;
        w_hour_c = r_hour;
        n_tick   = w_next_cnt[7:0];
        if (w_sec_tick) begin
            n_tick = 8'd0;
            if (r_sec == ckp_pkg::SEC_MAX) begin
                w_sec_c = 6'd0;
                if (r_min == ckp_pkg::MIN_MAX) begin
                    w_min_c  = 6'd0;
                    w_hour_c = (r_hour == ckp_pkg::HOUR_MAX) ? 5'd0 : r_hour + 5'd1;
                end else begin
                    w_min_c = r_min + 6'd1;
                end
            end else begin
                w_sec_c = r_sec + 6'd1;
            end
        end

        // keypad edits on the first tick of a key
        n_hour = w_hour_c;
        n_min  = w_min_c;
        n_sec  = w_sec_c;
        n_fld  = r_fld;
        if (w_key_new) begin
            case (i_key)
                ckp_pkg::BTN_RIGHT: begin
                    if (r_fld != ckp_pkg::FLD_SECOND) n_fld = r_fld + 2'd1;
                end
                ckp_pkg::BTN_LEFT: begin
                    n_fld = (r_fld == ckp_pkg::FLD_HOUR) ? ckp_pkg::FLD_SECOND
                                                         : r_fld - 2'd1;
                end
                ckp_pkg::BTN_UP, ckp_pkg::BTN_DOWN: begin
                    case (r_fld)
                        ckp_pkg::FLD_HOUR: begin
                            if (w_up) n_hour = (w_hour_c == ckp_pkg::HOUR_MAX) ? 5'd0
                                                                               : w_hour_c + 5'd1;
                            else      n_hour = (w_hour_c == 5'd0) ? ckp_pkg::HOUR_MAX
                                                                  : w_hour_c - 5'd1;
                        end
                        ckp_pkg::FLD_MINUTE: begin
                            if (w_up) n_min = (w_min_c == ckp_pkg::MIN_MAX) ? 6'd0
                                                                            : w_min_c + 6'd1;
                            else      n_min = (w_min_c == 6'd0) ? ckp_pkg::MIN_MAX
                                                                : w_min_c - 6'd1;
                        end
                        default: begin
                            if (w_up) n_sec = (w_sec_c == ckp_pkg::SEC_MAX) ? 6'd0
                                                                            : w_sec_c + 6'd1;
                            else      n_sec = (w_sec_c == 6'd0) ? ckp_pkg::SEC_MAX
                                                                : w_sec_c - 6'd1;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= 8'd0;
            r_hour <= ckp_pkg::HOUR_MAX;
            r_min  <= ckp_pkg::MIN_MAX;
            r_sec  <= 6'd50;
            r_fld  <= ckp_pkg::FLD_HOUR;
            r_last <= ckp_pkg::BTN_NONE;
        end else if (i_step) begin
            r_tick <= n_tick;
            r_hour <= n_hour;
            r_min  <= n_min;
            r_sec  <= n_sec;
            r_fld  <= n_fld;
            r_last <= i_key;
        end
    end

    // result register, payload only
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_res.hour_value     <= n_hour;
            r_res.minute_value   <= n_min;
            r_res.second_value   <= n_sec;
            r_res.selected_field <= n_fld;
            r_res.key_code       <= i_key;
            r_res.refresh        <= w_sec_tick | w_key_new;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

>>> design/clock_24h_with_keypad_setting.sv
// A tick item's sample is held in the input register, and its result then in the result register.
// One tick item per cycle unless a held result stalls the input; the time registers update in a single pass.
// Stalls: a held result keeps one more item in the input register, then ready drops.
// Reset (synchronous, active low): time 23:59:50, hours selected, no key held,
// tick prescaler at zero, ticks_per_second 125, key_tolerance 10.
`default_nettype none

module clock_24h_with_keypad_setting (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // tick item channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [9:0] i_adc_sample,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [4:0]      o_hour_value,
    output logic [5:0]      o_minute_value,
    output logic [5:0]      o_second_value,
    output logic [1:0]      o_selected_field,
    output logic [2:0]      o_key_code,
    output logic            o_refresh,
    // configuration writes
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    logic [7:0] r_tps;
    logic [5:0] r_tol;

    // input register: holds the sample of one item
    logic       r_in_valid;
    logic [9:0] r_sample;

    logic       r_out_valid;
    logic       w_advance;
    logic [2:0] w_key;

    ckp_pkg::t_result w_res;

    // Move an item into the result register when the result slot is free or
    // is being drained this cycle; the input register refills behind it.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= ckp_pkg::TPS_RESET;
            r_tol <= ckp_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ckp_pkg::CFG_TICKS_PER_SECOND: r_tps <= i_cfg_data;
                ckp_pkg::CFG_KEY_TOLERANCE:    r_tol <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (w_advance) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_sample <= i_adc_sample;
    end

    // classify the held sample against the ladder windows
    ckp_key_decode u_key_decode (
        .i_sample (r_sample),
        .i_tol    (r_tol),
        .o_key    (w_key)
    );

    // prescaler, time-of-day registers, field editing and result register
    ckp_time_core u_time_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_key   (w_key),
        .i_tps   (r_tps),
        .o_res   (w_res)
    );

    assign o_out_valid      = r_out_valid;
    assign o_hour_value     = w_res.hour_value;
    assign o_minute_value   = w_res.minute_value;
    assign o_second_value   = w_res.second_value;
    assign o_selected_field = w_res.selected_field;
    assign o_key_code       = w_res.key_code;
    assign o_refresh        = w_res.refresh;

endmodule

`default_nettype wire

>>> tb/clock_24h_with_keypad_setting_test.sv
`timescale 1ns / 100ps

module clock_24h_with_keypad_setting_test;

    localparam int RESET_CYCLES = 8;
    localparam int MAX_GAP      = 18;
    // Slowest run: ~700 items, each with a full send gap, a full stall and the
    // pass through both registers, plus the idle pauses between phases. Take it >10 times.
    localparam int CYCLE_LIMIT  = 400000;
    // Result passes the input register and the result register; leave margin on top.
    localparam int SETTLE_CYCLES = 6;

    typedef struct {
        logic [9:0]       sample;
        bit               typed;
        ckp_pkg::t_result want;
    } t_tick_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [9:0] i_adc_sample;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [4:0] o_hour_value;
    logic [5:0] o_minute_value;
    logic [5:0] o_second_value;
    logic [1:0] o_selected_field;
    logic [2:0] o_key_code;
    logic       o_refresh;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    // Shadow copy of the clock: configuration and state after the last tick.
    logic [7:0] cfg_tps;
    logic [5:0] cfg_tol;
    logic [7:0] clk_ticks;
    logic [4:0] clk_hour;
    logic [5:0] clk_min;
    logic [5:0] clk_sec;
    logic [1:0] edit_field;
    logic [2:0] held_key;

    ckp_pkg::t_result pending_times[$];
    t_tick_row        directed_rows[$];
    int               mismatches;
    int               cycle_count;
    bit               calm_in;
    bit               calm_out;

    clock_24h_with_keypad_setting u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_adc_sample     (i_adc_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_hour_value     (o_hour_value),
        .o_minute_value   (o_minute_value),
        .o_second_value   (o_second_value),
        .o_selected_field (o_selected_field),
        .o_key_code       (o_key_code),
        .o_refresh        (o_refresh),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("clock_24h_with_keypad_setting_test NOT OK");
            $finish;
        end
    end

    function automatic bit in_win(input int s, input int c, input int tol);
        return (s + tol >= c) && (s <= c + tol);
    endfunction

    // Advance the shadow clock by one tick and return what the block should show.
    function automatic ckp_pkg::t_result tick_clock(input logic [9:0] sample);
        ckp_pkg::t_result r;
        logic [2:0] key;
        int s;
        int tol;
        bit up;
        s = int'(sample);
        tol = int'(cfg_tol);
        r = '0;

        // Prescaler: a count of zero or one makes every tick a second.
        if (int'(clk_ticks) + 1 >= int'(cfg_tps)) begin
            clk_ticks = '0;
            r.refresh = 1'b1;
            if (clk_sec == ckp_pkg::SEC_MAX) begin
                clk_sec = '0;
                if (clk_min == ckp_pkg::MIN_MAX) begin
                    clk_min = '0;
                    clk_hour = (clk_hour == ckp_pkg::HOUR_MAX) ? 5'd0 : clk_hour + 5'd1;
                end else begin
                    clk_min = clk_min + 6'd1;
                end
            end else begin
                clk_sec = clk_sec + 6'd1;
            end
        end else begin
            clk_ticks = clk_ticks + 8'd1;
        end

        // Ladder windows, checked in order so the later key wins an overlap.
        key = ckp_pkg::BTN_NONE;
        if (s <= tol) key = ckp_pkg::BTN_RIGHT;
        if (in_win(s, int'(ckp_pkg::CENTER_UP), tol)) key = ckp_pkg::BTN_UP;
        if (in_win(s, int'(ckp_pkg::CENTER_DOWN), tol)) key = ckp_pkg::BTN_DOWN;
        if (in_win(s, int'(ckp_pkg::CENTER_LEFT), tol)) key = ckp_pkg::BTN_LEFT;
        if (in_win(s, int'(ckp_pkg::CENTER_SELECT), tol)) key = ckp_pkg::BTN_SELECT;

        // Act only on the first tick of a key; a released ladder clears the hold.
        if (key == ckp_pkg::BTN_NONE) begin
            held_key = ckp_pkg::BTN_NONE;
        end else begin
            if (key != held_key) begin
                up = (key == ckp_pkg::BTN_UP);
                case (key)
                    ckp_pkg::BTN_RIGHT: begin
                        if (edit_field != ckp_pkg::FLD_SECOND) edit_field = edit_field + 2'd1;
                    end
                    ckp_pkg::BTN_LEFT: begin
                        edit_field = (edit_field == ckp_pkg::FLD_HOUR) ? ckp_pkg::FLD_SECOND
                                                                       : edit_field - 2'd1;
                    end
                    ckp_pkg::BTN_UP, ckp_pkg::BTN_DOWN: begin
                        // Wrap inside the edited field, no carry into the next one.
                        if (edit_field == ckp_pkg::FLD_HOUR) begin
                            if (up)
                                clk_hour = (clk_hour == ckp_pkg::HOUR_MAX) ? 5'd0
                                                                           : clk_hour + 5'd1;
                            else
                                clk_hour = (clk_hour == 5'd0) ? ckp_pkg::HOUR_MAX
                                                              : clk_hour - 5'd1;
                        end else if (edit_field == ckp_pkg::FLD_MINUTE) begin
                            if (up)
                                clk_min = (clk_min == ckp_pkg::MIN_MAX) ? 6'd0
                                                                        : clk_min + 6'd1;
                            else
                                clk_min = (clk_min == 6'd0) ? ckp_pkg::MIN_MAX
                                                            : clk_min - 6'd1;
                        end else begin
                            if (up)
                                clk_sec = (clk_sec == ckp_pkg::SEC_MAX) ? 6'd0
                                                                        : clk_sec + 6'd1;
                            else
                                clk_sec = (clk_sec == 6'd0) ? ckp_pkg::SEC_MAX
                                                            : clk_sec - 6'd1;
                        end
                    end
                    default: ;
                endcase
                r.refresh = 1'b1;
            end
            held_key = key;
        end

        r.hour_value     = clk_hour;
        r.minute_value   = clk_min;
        r.second_value   = clk_sec;
        r.selected_field = edit_field;
        r.key_code       = key;
        return r;
    endfunction

    // Typed result for a directed row, time fixed at the reset value.
    function automatic ckp_pkg::t_result at_reset_time(input logic [1:0] fld,
                                                       input logic [2:0] key,
                                                       input logic refresh);
        ckp_pkg::t_result r;
        r.hour_value     = 5'd23;
        r.minute_value   = 6'd59;
        r.second_value   = 6'd50;
        r.selected_field = fld;
        r.key_code       = key;
        r.refresh        = refresh;
        return r;
    endfunction

    function automatic t_tick_row make_row(input logic [9:0] sample, input bit typed,
                                           input ckp_pkg::t_result want);
        t_tick_row row;
        row.sample = sample;
        row.typed  = typed;
        row.want   = want;
        return row;
    endfunction

    // Offer one tick item, hold it until taken, then log what it should produce.
    // Returns at the edge that accepted the item, with valid still high.
    task automatic send_tick(input logic [9:0] sample, input bit typed,
                             input ckp_pkg::t_result want);
        int gap;
        ckp_pkg::t_result predicted;
        if ($urandom_range(0, 31) == 0) calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_adc_sample <= sample;
        // Sample ready mid-cycle, where nothing is changing.
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        predicted = tick_clock(sample);
        pending_times.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        while (pending_times.size() != 0) @(posedge i_clk);
    endtask

    // Drop valid, let the block run dry, then leave time for the pipeline to empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges; only while the block is idle.
    task automatic write_config(input logic [7:0] tps, input logic [5:0] tol);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ckp_pkg::CFG_TICKS_PER_SECOND;
        i_cfg_data <= tps;
        @(posedge i_clk);
        i_cfg_idx  <= ckp_pkg::CFG_KEY_TOLERANCE;
        i_cfg_data <= {2'b00, tol};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_tps = tps;
        cfg_tol = tol;
    endtask

    // Random phase: mostly key presses held for a few ticks and released,
    // with raw ladder noise mixed in.
    task automatic run_phase(input logic [7:0] tps, input logic [5:0] tol, input int items);
        int sent;
        int hold;
        int lo;
        int hi;
        int center;
        sent = 0;
        settle();
        write_config(tps, tol);
        while (sent < items) begin
            if ($urandom_range(0, 4) == 0) begin
                send_tick(10'($urandom_range(0, 1023)), 1'b0, '0);
                sent++;
            end else begin
                case ($urandom_range(0, 4))
                    0:       center = -1;
                    1:       center = int'(ckp_pkg::CENTER_UP);
                    2:       center = int'(ckp_pkg::CENTER_DOWN);
                    3:       center = int'(ckp_pkg::CENTER_LEFT);
                    default: center = int'(ckp_pkg::CENTER_SELECT);
                endcase
                // Right sits at the bottom of the ladder: window is 0..tol.
                lo = (center < 0) ? 0 : center - int'(tol);
                hi = (center < 0) ? int'(tol) : center + int'(tol);
                hold = $urandom_range(1, 4);
                repeat (hold) begin
                    send_tick(10'($urandom_range(hi, lo)), 1'b0, '0);
                    sent++;
                end
                // Release: above every window for any tolerance.
                hold = $urandom_range(0, 2);
                repeat (hold) begin
                    send_tick(10'($urandom_range(870, 1023)), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // Result side: stall at random, take one item, compare with the oldest expectation.
    initial begin
        int stall;
        ckp_pkg::t_result got;
        ckp_pkg::t_result want;
        i_out_ready <= 1'b0;
        repeat (RESET_CYCLES + 1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
            stall = calm_out ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(negedge i_clk);
            while (!o_out_valid) @(negedge i_clk);
            got.hour_value     = o_hour_value;
            got.minute_value   = o_minute_value;
            got.second_value   = o_second_value;
            got.selected_field = o_selected_field;
            got.key_code       = o_key_code;
            got.refresh        = o_refresh;
            @(posedge i_clk);
            if (pending_times.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] stray result: %0d:%0d:%0d fld %0d key %0d ref %0d",
                             $realtime, got.hour_value, got.minute_value, got.second_value,
                             got.selected_field, got.key_code, got.refresh);
            end else begin
                want = pending_times.pop_front();
                if (got.hour_value !== want.hour_value ||
                    got.minute_value !== want.minute_value ||
                    got.second_value !== want.second_value ||
                    got.selected_field !== want.selected_field ||
                    got.key_code !== want.key_code ||
                    got.refresh !== want.refresh) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("[%0t] mismatch: expected %0d:%0d:%0d fld %0d key %0d ref %0d,",
                               $realtime, want.hour_value, want.minute_value,
                               want.second_value, want.selected_field, want.key_code,
                               want.refresh);
                        $display(" got %0d:%0d:%0d fld %0d key %0d ref %0d",
                                 got.hour_value, got.minute_value, got.second_value,
                                 got.selected_field, got.key_code, got.refresh);
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed table under reset configuration, random phases.
    initial begin
        calm_in      = 1'b0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_adc_sample <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= ckp_pkg::CFG_TICKS_PER_SECOND;
        i_cfg_data   <= '0;

        // Shadow state after reset.
        cfg_tps    = ckp_pkg::TPS_RESET;
        cfg_tol    = ckp_pkg::TOL_RESET;
        clk_ticks  = '0;
        clk_hour   = 5'd23;
        clk_min    = 6'd59;
        clk_sec    = 6'd50;
        edit_field = ckp_pkg::FLD_HOUR;
        held_key   = ckp_pkg::BTN_NONE;

        // Reset config: 125 ticks per second, so no second passes in this table.
        // Typed rows are read straight off the reset state.
        directed_rows.push_back(make_row(10'd1023, 1'b1,
            at_reset_time(ckp_pkg::FLD_HOUR, ckp_pkg::BTN_NONE, 1'b0)));
        directed_rows.push_back(make_row(10'd0, 1'b1,
            at_reset_time(ckp_pkg::FLD_MINUTE, ckp_pkg::BTN_RIGHT, 1'b1)));
        // top edge of the right window, still held
        directed_rows.push_back(make_row(10'd10, 1'b1,
            at_reset_time(ckp_pkg::FLD_MINUTE, ckp_pkg::BTN_RIGHT, 1'b0)));
        // just outside the right window
        directed_rows.push_back(make_row(10'd11, 1'b1,
            at_reset_time(ckp_pkg::FLD_MINUTE, ckp_pkg::BTN_NONE, 1'b0)));
        directed_rows.push_back(make_row(10'd0, 1'b1,
            at_reset_time(ckp_pkg::FLD_SECOND, ckp_pkg::BTN_RIGHT, 1'b1)));
        directed_rows.push_back(make_row(10'd803, 1'b0, '0));
        // right at seconds saturates
        directed_rows.push_back(make_row(10'd5, 1'b1,
            at_reset_time(ckp_pkg::FLD_SECOND, ckp_pkg::BTN_RIGHT, 1'b1)));
        // up/down at window edges, held and released
        directed_rows.push_back(make_row(10'd145, 1'b0, '0));
        directed_rows.push_back(make_row(10'd155, 1'b0, '0));
        directed_rows.push_back(make_row(10'd156, 1'b0, '0));
        directed_rows.push_back(make_row(10'd319, 1'b0, '0));
        directed_rows.push_back(make_row(10'd339, 1'b0, '0));
        directed_rows.push_back(make_row(10'd340, 1'b0, '0));
        // left, held, then select with no release in between
        directed_rows.push_back(make_row(10'd505, 1'b0, '0));
        directed_rows.push_back(make_row(10'd495, 1'b0, '0));
        directed_rows.push_back(make_row(10'd740, 1'b0, '0));
        directed_rows.push_back(make_row(10'd750, 1'b0, '0));
        directed_rows.push_back(make_row(10'd505, 1'b0, '0));
        // hours: up from 23 wraps to 0, down wraps back to 23
        directed_rows.push_back(make_row(10'd135, 1'b0, '0));
        directed_rows.push_back(make_row(10'd1023, 1'b0, '0));
        directed_rows.push_back(make_row(10'd329, 1'b0, '0));
        directed_rows.push_back(make_row(10'd1023, 1'b0, '0));
        directed_rows.push_back(make_row(10'd740, 1'b0, '0));
        // left at hours wraps to seconds
        directed_rows.push_back(make_row(10'd505, 1'b0, '0));
        directed_rows.push_back(make_row(10'd512, 1'b0, '0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_tick(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);

        // Extremes first: one tick per second with exact-match keys, zero
        // prescale, the slowest prescale, then a prescale of two and random ones.
        run_phase(8'd1, 6'd0, 120);
        run_phase(8'd0, 6'd63, 120);
        run_phase(8'd255, 6'd10, 120);
        run_phase(8'd2, 6'd63, 140);
        run_phase(8'($urandom_range(1, 12)), 6'($urandom_range(0, 63)), 150);

        settle();
        if (mismatches == 0)
            $display("clock_24h_with_keypad_setting_test OK");
        else
            $display("clock_24h_with_keypad_setting_test NOT OK");
        $finish;
    end

endmodule
